### rtl/core/segint_pkg.sv
`default_nettype none

package segint_pkg;

  // Default coordinate width: signed fixed point with 16 fraction bits.
  localparam int unsigned COORD_WIDTH_DEF = 32;

  // Sign of one orientation cross product. Both flags low means zero.
  typedef struct packed {
    logic pos;
    logic neg;
  } orient_sign_t;

endpackage : segint_pkg

`default_nettype wire

### rtl/core/segint_orient.sv
`default_nettype none

module segint_orient
  import segint_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic signed [COORD_WIDTH-1:0] seg_sx,
  input  wire logic signed [COORD_WIDTH-1:0] seg_sy,
  input  wire logic signed [COORD_WIDTH-1:0] seg_ex,
  input  wire logic signed [COORD_WIDTH-1:0] seg_ey,
  input  wire logic signed [COORD_WIDTH-1:0] pt_x,
  input  wire logic signed [COORD_WIDTH-1:0] pt_y,
  output orient_sign_t                       sign_o
);

  localparam int unsigned DiffWidth = COORD_WIDTH + 1;
  localparam int unsigned ProdWidth = 2 * DiffWidth;

  logic signed [DiffWidth-1:0] d_py;
  logic signed [DiffWidth-1:0] d_ex;
  logic signed [DiffWidth-1:0] d_px;
  logic signed [DiffWidth-1:0] d_ey;
  logic signed [ProdWidth-1:0] prod_p;
  logic signed [ProdWidth-1:0] prod_q;

  // Differences carry one extra bit so they never overflow.
  assign d_py = {pt_y[COORD_WIDTH-1], pt_y}     - {seg_sy[COORD_WIDTH-1], seg_sy};
  assign d_ex = {seg_ex[COORD_WIDTH-1], seg_ex} - {seg_sx[COORD_WIDTH-1], seg_sx};
  assign d_px = {pt_x[COORD_WIDTH-1], pt_x}     - {seg_sx[COORD_WIDTH-1], seg_sx};
  assign d_ey = {seg_ey[COORD_WIDTH-1], seg_ey} - {seg_sy[COORD_WIDTH-1], seg_sy};

  // Exact products at full width; the cross product sign is their comparison.
  assign prod_p = d_py * d_ex;
  assign prod_q = d_px * d_ey;

  assign sign_o.pos = (prod_p > prod_q);
  assign sign_o.neg = (prod_p < prod_q);

endmodule : segint_orient

`default_nettype wire

### rtl/core/segment_intersection_test_unit.sv
`default_nettype none

// Each item passes through the input register and then the result register, which drives the result strobe.
// Throughput: one item per cycle; busy is held low, as nothing carries between items.
// The critical path is one coordinate subtract, one exact product and a compare.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset clears the valid flags of the input and result registers only.
module segment_intersection_test_unit
  import segint_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_end_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_end_y,
  output      logic                          out_valid,
  output      logic                          out_intersects
);

  logic                          in_valid_r;
  logic signed [COORD_WIDTH-1:0] asx_r, asy_r, aex_r, aey_r;
  logic signed [COORD_WIDTH-1:0] bsx_r, bsy_r, bex_r, bey_r;
  logic                          out_valid_r;
  logic                          out_intersects_r;
  logic                          intersects_nxt;
  logic                          shared_pt;
  logic                          collinear;
  logic                          opp_a;
  logic                          opp_b;
  logic                          zero_a;
  logic                          zero_b;
  orient_sign_t                  s1, s2, s3, s4;

  // The block never holds off an item.
  assign busy = 1'b0;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      asx_r <= in_first_start_x;
      asy_r <= in_first_start_y;
      aex_r <= in_first_end_x;
      aey_r <= in_first_end_y;
      bsx_r <= in_second_start_x;
      bsy_r <= in_second_start_y;
      bex_r <= in_second_end_x;
      bey_r <= in_second_end_y;
    end
  end

  // Four orientation signs: second segment's ends against the first, and back.
  segint_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_1 (
    .seg_sx(asx_r), .seg_sy(asy_r), .seg_ex(aex_r), .seg_ey(aey_r),
    .pt_x(bsx_r), .pt_y(bsy_r), .sign_o(s1)
  );
  segint_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_2 (
    .seg_sx(asx_r), .seg_sy(asy_r), .seg_ex(aex_r), .seg_ey(aey_r),
    .pt_x(bex_r), .pt_y(bey_r), .sign_o(s2)
  );
  segint_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_3 (
    .seg_sx(bsx_r), .seg_sy(bsy_r), .seg_ex(bex_r), .seg_ey(bey_r),
    .pt_x(asx_r), .pt_y(asy_r), .sign_o(s3)
  );
  segint_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_4 (
    .seg_sx(bsx_r), .seg_sy(bsy_r), .seg_ex(bex_r), .seg_ey(bey_r),
    .pt_x(aex_r), .pt_y(aey_r), .sign_o(s4)
  );

  // Any end point of one segment equal to any end point of the other.
  assign shared_pt = ((asx_r == bsx_r) && (asy_r == bsy_r)) ||
                     ((asx_r == bex_r) && (asy_r == bey_r)) ||
                     ((aex_r == bsx_r) && (aey_r == bsy_r)) ||
                     ((aex_r == bex_r) && (aey_r == bey_r));

  // A pair is opposite when its signs sum to zero, which includes both zero.
  assign opp_a  = (s1.pos == s2.neg) && (s1.neg == s2.pos);
  assign opp_b  = (s3.pos == s4.neg) && (s3.neg == s4.pos);
  assign zero_a = (s1 == '0) || (s2 == '0);
  assign zero_b = (s3 == '0) || (s4 == '0);
  assign collinear = (s1 == '0) && (s2 == '0) && (s3 == '0) && (s4 == '0);

  // Crossing or touching, with shared end points and collinear pairs rejected.
  always_comb begin
    intersects_nxt = 1'b0;
    if (!shared_pt && !collinear) begin
      intersects_nxt = (opp_a && opp_b) || (opp_a && zero_b) || (opp_b && zero_a);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_intersects_r <= intersects_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_intersects = out_intersects_r;

  // Every registered item yields exactly one strobe in the next cycle.
  a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |=> out_valid_r)
    else $error("item in the input register produced no result strobe");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |=> !out_valid_r)
    else $error("result strobe without a registered item");

  // Shared end points and fully collinear pairs never report a hit.
  a_reject_cases: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && (shared_pt || collinear)) |=> !out_intersects_r)
    else $error("shared end point or collinear pair reported as intersecting");

endmodule : segment_intersection_test_unit

`default_nettype wire

### verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import segint_pkg::*;

  localparam int unsigned CW = COORD_WIDTH_DEF;
  localparam int MAX_REPORTS = 10;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_LIMIT = 100;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PER_PHASE = 345;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t fsx, fsy, fex, fey;
    coord_t ssx, ssy, sex, sey;
  } seg_pair_t;

  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t UNIT = 65536;

  // Holds the predicted answer of every accepted item until its result strobes.
  class intersect_scoreboard;
    bit hit_q[$];
    int fail_count;

    function void note_failure(string what, int want, int got);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("tb: %s at %0t: expected %0d, actual %0d", what, $realtime, want, got);
      end
    endfunction

    // Exact sign of the cross product of point p against the segment s to e.
    function int orient_sign(input coord_t sx, sy, ex, ey, px, py);
      logic signed [CW+1:0] dpy, dex, dpx, dey;
      logic signed [2*CW+5:0] cross_prod;
      dpy = py - sy;
      dex = ex - sx;
      dpx = px - sx;
      dey = ey - sy;
      cross_prod = dpy * dex - dpx * dey;
      if (cross_prod == 0) return 0;
      return (cross_prod < 0) ? -1 : 1;
    endfunction

    function bit predict_hit(seg_pair_t p);
      int s1, s2, s3, s4;
      // Any endpoint shared between the segments rules out a hit.
      if ((p.fsx == p.ssx && p.fsy == p.ssy) || (p.fsx == p.sex && p.fsy == p.sey) ||
          (p.fex == p.ssx && p.fey == p.ssy) || (p.fex == p.sex && p.fey == p.sey)) begin
        return 1'b0;
      end
      s1 = orient_sign(p.fsx, p.fsy, p.fex, p.fey, p.ssx, p.ssy);
      s2 = orient_sign(p.fsx, p.fsy, p.fex, p.fey, p.sex, p.sey);
      s3 = orient_sign(p.ssx, p.ssy, p.sex, p.sey, p.fsx, p.fsy);
      s4 = orient_sign(p.ssx, p.ssy, p.sex, p.sey, p.fex, p.fey);
      // Fully collinear pairs never count, even when they overlap.
      if (s1 == 0 && s2 == 0 && s3 == 0 && s4 == 0) return 1'b0;
      return ((s1 + s2) == 0 && (s3 + s4) == 0) ||
             ((s1 + s2) == 0 && (s3 * s4) == 0) ||
             ((s3 + s4) == 0 && (s1 * s2) == 0);
    endfunction

    function void note_item(seg_pair_t p);
      hit_q.push_back(predict_hit(p));
    endfunction

    function void check_result(logic actual);
      bit want;
      if (hit_q.size() == 0) begin
        note_failure("result with no item waiting", -1, actual);
        return;
      end
      want = hit_q.pop_front();
      if (actual !== want) note_failure("intersects mismatch", want, actual);
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t in_first_start_x = '0;
  coord_t in_first_start_y = '0;
  coord_t in_first_end_x = '0;
  coord_t in_first_end_y = '0;
  coord_t in_second_start_x = '0;
  coord_t in_second_start_y = '0;
  coord_t in_second_end_x = '0;
  coord_t in_second_end_y = '0;
  logic out_valid;
  logic out_intersects;

  intersect_scoreboard sb = new();
  int stall_cycles = 0;

  segment_intersection_test_unit #(
    .COORD_WIDTH(CW)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_first_start_x (in_first_start_x),
    .in_first_start_y (in_first_start_y),
    .in_first_end_x   (in_first_end_x),
    .in_first_end_y   (in_first_end_y),
    .in_second_start_x(in_second_start_x),
    .in_second_start_y(in_second_start_y),
    .in_second_end_x  (in_second_end_x),
    .in_second_end_y  (in_second_end_y),
    .out_valid        (out_valid),
    .out_intersects   (out_intersects)
  );

  // Clock: 1 ns high, 1 ns low.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic seg_pair_t seg_pair(input coord_t a, b, c, d, e, f, g, h);
    seg_pair_t p;
    p.fsx = a;
    p.fsy = b;
    p.fex = c;
    p.fey = d;
    p.ssx = e;
    p.ssy = f;
    p.sex = g;
    p.sey = h;
    return p;
  endfunction

  // Coordinates on a tiny grid, in raw units or whole units, to hit zero signs often.
  function automatic coord_t small_coord();
    coord_t v;
    v = coord_t'(int'($urandom_range(8)) - 4);
    return $urandom_range(1) ? v * UNIT : v;
  endfunction

  // Random coordinate within a quarter of the range, so sums stay in range.
  function automatic coord_t half_coord();
    return coord_t'($signed($urandom) >>> 2);
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(5))
      0: return CMIN;
      1: return CMAX;
      2: return '0;
      3: return -1;
      4: return 1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Mix of fully random, tiny-grid and extreme pairs and well-formed touching, shared and collinear pairs.
  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int unsigned kind;
    coord_t dx, dy, bx, by;
    int t0, t1, t2, t3;
    kind = $urandom_range(99);
    p = seg_pair($urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom);
    if (kind < 35) begin
      return p;
    end else if (kind < 55) begin
      p = seg_pair(small_coord(), small_coord(), small_coord(), small_coord(),
                   small_coord(), small_coord(), small_coord(), small_coord());
    end else if (kind < 70) begin
      // An endpoint of the second segment sits on the midpoint of the first.
      dx = half_coord();
      dy = half_coord();
      p.fsx = half_coord();
      p.fsy = half_coord();
      p.fex = p.fsx + 2 * dx;
      p.fey = p.fsy + 2 * dy;
      if ($urandom_range(1)) begin
        p.ssx = p.fsx + dx;
        p.ssy = p.fsy + dy;
      end else begin
        p.sex = p.fsx + dx;
        p.sey = p.fsy + dy;
      end
    end else if (kind < 80) begin
      case ($urandom_range(3))
        0: begin p.ssx = p.fsx; p.ssy = p.fsy; end
        1: begin p.sex = p.fsx; p.sey = p.fsy; end
        2: begin p.ssx = p.fex; p.ssy = p.fey; end
        default: begin p.sex = p.fex; p.sey = p.fey; end
      endcase
    end else if (kind < 90) begin
      p = seg_pair(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                   extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
    end else begin
      // Four points along one line, overlapping or apart.
      bx = half_coord();
      by = half_coord();
      dx = coord_t'(int'($urandom_range(8191)) - 4096);
      dy = coord_t'(int'($urandom_range(8191)) - 4096);
      t0 = int'($urandom_range(16)) - 8;
      t1 = int'($urandom_range(16)) - 8;
      t2 = int'($urandom_range(16)) - 8;
      t3 = int'($urandom_range(16)) - 8;
      p = seg_pair(bx + t0 * dx, by + t0 * dy, bx + t1 * dx, by + t1 * dy,
                   bx + t2 * dx, by + t2 * dy, bx + t3 * dx, by + t3 * dy);
    end
    return p;
  endfunction

  // Offers one item after a random number of idle cycles and waits for acceptance.
  task automatic send_item(seg_pair_t p, int idle_pct);
    while (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_first_start_x <= p.fsx;
    in_first_start_y <= p.fsy;
    in_first_end_x <= p.fex;
    in_first_end_y <= p.fey;
    in_second_start_x <= p.ssx;
    in_second_start_y <= p.ssy;
    in_second_end_x <= p.sex;
    in_second_end_y <= p.sey;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Observe both channels at every edge and track cycles without progress.
  always @(posedge clk) begin
    logic took_item;
    logic took_result;
    took_item = rst_n && start && (busy === 1'b0);
    took_result = rst_n && (out_valid !== 1'b0);
    if (took_item) begin
      sb.note_item(seg_pair(in_first_start_x, in_first_start_y, in_first_end_x,
                            in_first_end_y, in_second_start_x, in_second_start_y,
                            in_second_end_x, in_second_end_y));
    end
    if (took_result) sb.check_result(out_intersects);
    stall_cycles = (took_item || took_result) ? 0 : stall_cycles + 1;
  end

  // Watchdog.
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    seg_pair_t directed_q[$];
    int idle_pct[3];
    int waited;
    idle_pct[0] = 20;
    idle_pct[1] = 81;
    idle_pct[2] = 0;

    // Crossing, parallel and a T-shaped touch.
    directed_q.push_back(seg_pair(0, 0, 4*UNIT, 4*UNIT, 0, 4*UNIT, 4*UNIT, 0));
    directed_q.push_back(seg_pair(0, 0, 4*UNIT, 0, 0, UNIT, 4*UNIT, UNIT));
    directed_q.push_back(seg_pair(0, 0, 4*UNIT, 0, 2*UNIT, 0, 2*UNIT, 3*UNIT));
    // Each way of sharing an endpoint.
    directed_q.push_back(seg_pair(0, 0, 4*UNIT, 4*UNIT, 0, 0, 4*UNIT, 0));
    directed_q.push_back(seg_pair(0, 0, 4*UNIT, 4*UNIT, 4*UNIT, 0, 0, 0));
    directed_q.push_back(seg_pair(0, 0, 4*UNIT, 4*UNIT, 4*UNIT, 4*UNIT, 4*UNIT, 0));
    directed_q.push_back(seg_pair(0, 0, 4*UNIT, 4*UNIT, 0, 4*UNIT, 4*UNIT, 4*UNIT));
    // Collinear, overlapping and apart.
    directed_q.push_back(seg_pair(0, 0, 4*UNIT, 0, UNIT, 0, 6*UNIT, 0));
    directed_q.push_back(seg_pair(0, 0, UNIT, 0, 3*UNIT, 0, 6*UNIT, 0));
    // Degenerate segments: on the other segment, off it, and both at one point.
    directed_q.push_back(seg_pair(2*UNIT, 0, 2*UNIT, 0, 0, 0, 4*UNIT, 0));
    directed_q.push_back(seg_pair(0, 0, 4*UNIT, 0, UNIT, UNIT, UNIT, UNIT));
    directed_q.push_back(seg_pair(UNIT, UNIT, UNIT, UNIT, UNIT, UNIT, UNIT, UNIT));
    // Lines cross outside the segments; endpoint on the other line only.
    directed_q.push_back(seg_pair(0, 0, UNIT, UNIT, 4*UNIT, 0, 3*UNIT, UNIT));
    directed_q.push_back(seg_pair(0, 0, UNIT, 0, 2*UNIT, 0, 2*UNIT, UNIT));
    // Full-range coordinates.
    directed_q.push_back(seg_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
    directed_q.push_back(seg_pair(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX));
    directed_q.push_back(seg_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN + 1, CMAX, CMAX - 1));
    directed_q.push_back(seg_pair(CMIN, 0, CMAX, 0, 0, CMIN, 0, 0));
    directed_q.push_back(seg_pair(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN));
    directed_q.push_back(seg_pair(0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(seg_pair(-1, -1, 1, 1, -1, 1, 1, -1));
    directed_q.push_back(seg_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                                  32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                                  32'hAAAA_AAAA));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_q[i]) send_item(directed_q[i], 0);
    foreach (idle_pct[ph]) begin
      repeat (RANDOM_PER_PHASE) send_item(random_pair(), idle_pct[ph]);
    end
    start <= 1'b0;

    // Let the pipeline empty, then keep watching for stray strobes.
    waited = 0;
    while (sb.hit_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.hit_q.size() != 0) sb.note_failure("items left without result", 0, sb.hit_q.size());

    if (sb.fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### segment_intersection_test_unit.f
rtl/core/segint_pkg.sv
rtl/core/segint_orient.sv
rtl/core/segment_intersection_test_unit.sv
verif/tb.sv
